// ===== hdl/sliding_window_median_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window median filter: assertion macros
// Shared property shapes for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH

// condition in this cycle implies a consequence in the next one
`define SWMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// condition in this cycle implies a consequence in the same cycle
`define SWMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/swmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window median filter package
// Sizes, word types and the structs passed between the sorted cells.
// ----------------------------------------------------------------------------
package swmf_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int MIN_WINDOW = 3;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 6;
    // window length 3..MAX_WINDOW
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    // sample age 0..MAX_WINDOW-1, also a cell index
    localparam int AGE_W      = $clog2(MAX_WINDOW);

    typedef logic signed [DATA_W-1:0] swmf_word_t;
    typedef logic [AGE_W-1:0]         swmf_age_t;
    typedef logic [LEN_W-1:0]         swmf_len_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic [AGE_W-1:0]         age;
        logic                     gt;      // val above the incoming word
        logic                     active;  // cell inside the window
    } swmf_link_t;

    // broadcast to every cell
    typedef struct packed {
        logic                     shift;   // a word is accepted
        logic                     fill;    // load every active cell with the word
        logic signed [DATA_W-1:0] sample;
        logic [LEN_W-1:0]         win_len;
        logic [AGE_W-1:0]         oldest;  // age of the word that leaves
        logic                     rm_gt;   // leaving word is above the new one
    } swmf_ctl_t;

endpackage

// ===== hdl/swmf_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted window cell
// Holds one window word and its age. On each accepted word the row drops
// the oldest entry and inserts the new one, each cell taking its own,
// its left or its right neighbor's entry, or the new word.
// ----------------------------------------------------------------------------
module swmf_cell (
    input  logic                   aclk,
    input  swmf_pkg::swmf_age_t    cell_idx,
    input  swmf_pkg::swmf_ctl_t    ctl,
    input  swmf_pkg::swmf_link_t   left_link,
    input  swmf_pkg::swmf_link_t   right_link,
    input  logic                   rm_below_in,
    output swmf_pkg::swmf_link_t   own_link,
    output logic                   rm_below_out,
    output logic                   rm_gt
);
    import swmf_pkg::*;

    swmf_word_t val_reg, val_next;
    swmf_age_t  age_reg, age_next;
    logic       active, gt, rm, up_gt;

    // local compare and removal flags
    assign active       = swmf_len_t'(cell_idx) < ctl.win_len;
    assign gt           = active && ($signed(val_reg) > $signed(ctl.sample));
    assign rm           = active && (age_reg == ctl.oldest);
    assign rm_below_out = rm_below_in | rm;
    assign rm_gt        = rm & gt;
    // past the window end counts as "above"
    assign up_gt        = !right_link.active || right_link.gt;

    assign own_link = '{val: val_reg, age: age_reg, gt: gt, active: active};

    // insert/delete step
    always_comb begin
        val_next = val_reg;
        age_next = swmf_age_t'(age_reg + 1'b1);
        if (ctl.fill) begin
            val_next = ctl.sample;
            age_next = cell_idx;
        end else if (ctl.rm_gt) begin
            // new word lands at or below the gap: entries up to it move right
            if (!rm_below_in && gt) begin
                if (!left_link.gt) begin
                    val_next = ctl.sample;
                    age_next = '0;
                end else begin
                    val_next = left_link.val;
                    age_next = swmf_age_t'(left_link.age + 1'b1);
                end
            end
        end else begin
            // new word lands at or above the gap: entries from it move left
            if (rm_below_in || rm) begin
                if (!up_gt) begin
                    val_next = right_link.val;
                    age_next = swmf_age_t'(right_link.age + 1'b1);
                end else if (!gt || rm) begin
                    val_next = ctl.sample;
                    age_next = '0;
                end
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge aclk) begin
        if (ctl.shift && active) begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

// ===== hdl/swmf_median.sv =====
// ----------------------------------------------------------------------------
// Median select stage
// Picks the middle cell of the sorted row, or averages the two middle
// cells for an even window (floor of the 33-bit sum halved).
// ----------------------------------------------------------------------------
module swmf_median (
    input  logic                  aclk,
    input  logic                  load,
    input  swmf_pkg::swmf_len_t   win_len,
    input  swmf_pkg::swmf_word_t  vals [swmf_pkg::MAX_WINDOW],
    output swmf_pkg::swmf_word_t  median
);
    import swmf_pkg::*;

    swmf_age_t             mid_idx, lo_idx;
    swmf_word_t            v_hi, v_lo, median_reg, median_next;
    logic signed [DATA_W:0] pair_sum;

    // middle index is n/2; lower neighbor only used for even n (n >= 4)
    assign mid_idx  = swmf_age_t'(win_len >> 1);
    assign lo_idx   = swmf_age_t'(mid_idx - 1'b1);
    assign v_hi     = vals[mid_idx];
    assign v_lo     = vals[lo_idx];
    assign pair_sum = {v_lo[DATA_W-1], v_lo} + {v_hi[DATA_W-1], v_hi};

    always_comb begin
        if (win_len[0]) begin
            median_next = v_hi;
        end else begin
            median_next = pair_sum[DATA_W:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            median_reg <= median_next;
        end
    end

    assign median = median_reg;

endmodule

// ===== hdl/sliding_window_median_filter.sv =====
// ----------------------------------------------------------------------------
// Sliding window median filter
// Running median of signed Q16.16 words over a 3..32 word window.
// ----------------------------------------------------------------------------
// Takes one word per clock while the result side keeps up. The accepting
// edge updates a row of sorted cells (drop the oldest entry, insert the
// new word). Once the output register is free, it is loaded from the row
// through the middle-select/average stage. The row update is what sets
// the one-word-per-clock figure. A result word held back by the
// receiver stalls the input once one more word is pending. A write to the
// window length makes the next word refill the whole window with copies of
// itself, as does a word with restart set; lengths below 3 act as 3, above
// 32 as 32.
// ----------------------------------------------------------------------------
`include "sliding_window_median_filter_defines.svh"

module sliding_window_median_filter (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [swmf_pkg::CFG_W-1:0]   cfg_window_length,
    // input words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [swmf_pkg::DATA_W-1:0] s_sample,
    input  logic                         s_restart,
    input  logic                         s_block_end,
    // result words
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [swmf_pkg::DATA_W-1:0] m_median,
    output logic                         m_block_end_out
);
    import swmf_pkg::*;

    swmf_len_t  win_len_reg, win_len_next, cfg_len;
    logic       primed_reg, primed_next;
    logic       pend_reg, pend_next;
    logic       pend_be_reg;
    logic       m_valid_reg, m_valid_next;
    logic       m_be_reg;
    logic       accept, out_free, move, cfg_wr;

    swmf_ctl_t  ctl;
    swmf_link_t links [MAX_WINDOW];
    swmf_link_t edge_link;
    logic [MAX_WINDOW:0]   rm_chain;
    logic [MAX_WINDOW-1:0] rm_gt_vec;
    swmf_word_t cell_vals [MAX_WINDOW];
    swmf_word_t median_w;

    // handshake
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign out_free  = !m_valid_reg || m_ready;
    assign move      = pend_reg && out_free;
    assign s_ready   = !pend_reg || out_free;
    assign accept    = s_valid && s_ready;

    // clamp the requested length
    always_comb begin
        if (32'(cfg_window_length) < 32'(MIN_WINDOW)) begin
            cfg_len = swmf_len_t'(MIN_WINDOW);
        end else if (32'(cfg_window_length) > 32'(MAX_WINDOW)) begin
            cfg_len = swmf_len_t'(MAX_WINDOW);
        end else begin
            cfg_len = swmf_len_t'(cfg_window_length);
        end
    end

    // control next state
    always_comb begin
        win_len_next = cfg_wr ? cfg_len : win_len_reg;
        primed_next  = cfg_wr ? 1'b0 : (primed_reg | accept);
        pend_next    = accept || (pend_reg && !move);
        m_valid_next = move || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= swmf_len_t'(MIN_WINDOW);
            primed_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            win_len_reg <= win_len_next;
            primed_reg  <= primed_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // block-end mark follows its word
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_be_reg <= s_block_end;
        end
        if (move) begin
            m_be_reg <= pend_be_reg;
        end
    end

    // broadcast to the cell row
    assign ctl = '{shift:   accept,
                   fill:    !primed_reg || s_restart,
                   sample:  s_sample,
                   win_len: win_len_reg,
                   oldest:  swmf_age_t'(win_len_reg - 1'b1),
                   rm_gt:   |rm_gt_vec};

    assign edge_link   = '0;
    assign rm_chain[0] = 1'b0;

    // sorted cell row
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        swmf_link_t lft, rgt;
        if (g == 0) begin : g_first
            assign lft = edge_link;
        end else begin : g_mid_l
            assign lft = links[g-1];
        end
        if (g == MAX_WINDOW - 1) begin : g_last
            assign rgt = edge_link;
        end else begin : g_mid_r
            assign rgt = links[g+1];
        end

        swmf_cell u_cell (
            .aclk         (aclk),
            .cell_idx     (swmf_age_t'(g)),
            .ctl          (ctl),
            .left_link    (lft),
            .right_link   (rgt),
            .rm_below_in  (rm_chain[g]),
            .own_link     (links[g]),
            .rm_below_out (rm_chain[g+1]),
            .rm_gt        (rm_gt_vec[g])
        );

        assign cell_vals[g] = links[g].val;
    end

    // middle select and output register
    swmf_median u_median (
        .aclk    (aclk),
        .load    (move),
        .win_len (win_len_reg),
        .vals    (cell_vals),
        .median  (median_w)
    );

    assign m_valid         = m_valid_reg;
    assign m_median        = median_w;
    assign m_block_end_out = m_be_reg;

    // checks
    `SWMF_ASSERT_NEXT(a_move_fills_out, move, m_valid_reg, "result lost on its way out")
    `SWMF_ASSERT_NEXT(a_accept_primes, accept && !cfg_wr, primed_reg && pend_reg,
                      "accepted word left no pending window")
    `SWMF_ASSERT_NOW(a_len_range, 1'b1,
                     (win_len_reg >= swmf_len_t'(MIN_WINDOW)) &&
                     (win_len_reg <= swmf_len_t'(MAX_WINDOW)),
                     "window length out of range")
    `SWMF_ASSERT_NOW(a_one_oldest, pend_reg && !accept, rm_chain[MAX_WINDOW],
                     "no window entry carries the oldest age")

endmodule

// ===== tb/sv/sliding_window_median_filter_tb.sv =====
// ----------------------------------------------------------------------------
// Sliding window median filter testbench
// Drives signed Q16.16 words through the filter under random back-pressure,
// predicts every median with a sorted copy of the window and compares the
// result words in order. A short directed table covers the value extremes,
// restart, even-length averaging and the window length clamps. Random phases
// with a fresh window length each follow it.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swmf_pkg::*;

    localparam int RANDOM_WORDS = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic {ROW_WORD, ROW_LEN} row_kind_t;

    // one directed step: either a word to send or a window length to write
    typedef struct packed {
        row_kind_t         kind;
        logic [CFG_W-1:0]  len;
        logic [DATA_W-1:0] sample;
        logic              restart;
        logic              blk;
        logic              typed;
        logic [DATA_W-1:0] typed_median;
    } dir_row_t;

    typedef struct packed {
        swmf_word_t median;
        logic       blk_end;
    } median_word_t;

    localparam int NUM_DIR_ROWS = 26;
    localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
        // window of 3 after reset, first word fills the history
        '{ROW_WORD, 6'd0,  32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{ROW_WORD, 6'd0,  32'h8000_0000, 1'b1, 1'b0, 1'b1, 32'h8000_0000},
        '{ROW_WORD, 6'd0,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        // short window clamps to 3
        '{ROW_LEN,  6'd0,  32'h0,         1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'h1234_5678, 1'b0, 1'b0, 1'b1, 32'h1234_5678},
        '{ROW_WORD, 6'd0,  32'h8000_0000, 1'b0, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0},
        // even window, middle pair sums overflow 32 bits
        '{ROW_LEN,  6'd4,  32'h0,         1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF},
        '{ROW_WORD, 6'd0,  32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'h8000_0000, 1'b0, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1, 32'h7FFF_FFFF},
        // long window clamps to 32
        '{ROW_LEN,  6'd63, 32'h0,         1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'hFFFF_0000, 1'b0, 1'b0, 1'b1, 32'hFFFF_0000},
        '{ROW_WORD, 6'd0,  32'h0000_8000, 1'b0, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'h8000_0001, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_LEN,  6'd2,  32'h0,         1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'h0000_0001, 1'b0, 1'b1, 1'b1, 32'h0000_0001},
        '{ROW_WORD, 6'd0,  32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_LEN,  6'd32, 32'h0,         1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 6'd0,  32'h8000_0000, 1'b0, 1'b0, 1'b1, 32'h8000_0000},
        '{ROW_WORD, 6'd0,  32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0}
    };

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_window_length;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_sample;
    logic                     s_restart;
    logic                     s_block_end;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_median;
    logic                     m_block_end_out;

    // predicted filter state
    logic [CFG_W-1:0] len_setting;
    swmf_word_t       win_history [MAX_WINDOW-1];
    logic             hist_primed;

    median_word_t pending_medians [$];
    int           mismatches;
    int           results_seen;
    logic         steady_flow;
    logic         hold_req;

    sliding_window_median_filter dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_window_length (cfg_window_length),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample          (s_sample),
        .s_restart         (s_restart),
        .s_block_end       (s_block_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_median          (m_median),
        .m_block_end_out   (m_block_end_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // median of stored history plus the new word; advances the history
    function automatic median_word_t next_median(swmf_word_t smp, logic restart, logic blk);
        swmf_word_t               win [MAX_WINDOW];
        swmf_word_t               key;
        logic signed [DATA_W:0]   pair_sum;
        median_word_t             res;
        int                       n;
        int                       i;
        int                       j;
        n = int'(len_setting);
        if (n < MIN_WINDOW) n = MIN_WINDOW;
        if (n > MAX_WINDOW) n = MAX_WINDOW;
        if (!hist_primed || restart) begin
            for (i = 0; i < n - 1; i++) win_history[i] = smp;
            hist_primed = 1'b1;
        end
        for (i = 0; i < n - 1; i++) win[i] = win_history[i];
        win[n-1] = smp;
        for (i = 0; i < n - 1; i++) win_history[i] = win[i+1];
        // insertion sort, ascending
        for (i = 1; i < n; i++) begin
            key = win[i];
            j = i;
            while (j > 0 && win[j-1] > key) begin
                win[j] = win[j-1];
                j--;
            end
            win[j] = key;
        end
        if (n % 2 == 1) begin
            res.median = win[n/2];
        end else begin
            // 33-bit sum, arithmetic halving rounds toward minus infinity
            pair_sum = (DATA_W+1)'(win[n/2-1]) + (DATA_W+1)'(win[n/2]);
            res.median = pair_sum[DATA_W:1];
        end
        res.blk_end = blk;
        return res;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic swmf_word_t pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom;
        if (r < 75) return $signed($urandom_range(0, 16)) - 8;   // many ties near zero
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    endfunction

    function automatic logic [CFG_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return CFG_W'($urandom_range(0, 2));
        if (r < 24) return CFG_W'($urandom_range(MAX_WINDOW + 1, 63));
        if (r < 34) return CFG_W'(MAX_WINDOW);
        if (r < 44) return CFG_W'(MIN_WINDOW);
        return CFG_W'($urandom_range(MIN_WINDOW, MAX_WINDOW));
    endfunction

    task automatic send_word(swmf_word_t smp, logic restart, logic blk,
                             logic typed, swmf_word_t typed_median);
        int           gap;
        median_word_t want;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample    <= smp;
        s_restart   <= restart;
        s_block_end <= blk;
        do @(posedge aclk); while (!s_ready);
        want = next_median(smp, restart, blk);
        if (typed) want.median = typed_median;
        pending_medians.push_back(want);
    endtask

    // sender pause: nothing offered until every result word is back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge aclk);
    endtask

    task automatic write_length(logic [CFG_W-1:0] len);
        @(negedge aclk);
        cfg_valid         <= 1'b1;
        cfg_window_length <= len;
        do @(posedge aclk); while (!cfg_ready);
        len_setting = len;
        hist_primed = 1'b0;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        int words_sent;
        int phase;
        int phase_len;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_sample          = '0;
        s_restart         = 1'b0;
        s_block_end       = 1'b0;
        cfg_valid         = 1'b0;
        cfg_window_length = '0;
        steady_flow       = 1'b0;
        hold_req          = 1'b0;
        len_setting       = CFG_W'(MIN_WINDOW);
        hist_primed       = 1'b0;
        words_sent        = 0;
        phase             = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[k]) begin
            if (DIR_ROWS[k].kind == ROW_LEN) begin
                drain_results();
                write_length(DIR_ROWS[k].len);
            end else begin
                send_word(DIR_ROWS[k].sample, DIR_ROWS[k].restart, DIR_ROWS[k].blk,
                          DIR_ROWS[k].typed, DIR_ROWS[k].typed_median);
            end
        end

        // random phases, each with its own window length
        while (words_sent < RANDOM_WORDS) begin
            drain_results();
            write_length(pick_length());
            steady_flow = ($urandom_range(0, 4) == 0);
            phase_len   = $urandom_range(20, 120);
            if (phase == 1) begin
                // long receiver stall while words keep coming
                steady_flow = 1'b0;
                hold_req    = 1'b1;
                phase_len   = 150;
            end
            repeat (phase_len) begin
                send_word(pick_sample(), $urandom_range(0, 99) < 4,
                          $urandom_range(0, 3) == 0, 1'b0, '0);
                words_sent++;
            end
            phase++;
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending_medians.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side back-pressure
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && stall_left == 0) begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(1, 3);
            end
            m_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge aclk) begin
        median_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_medians.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result word %0d with none expected: median %h block_end %b",
                             results_seen, m_median, m_block_end_out);
            end else begin
                want = pending_medians.pop_front();
                if (want.median !== m_median || want.blk_end !== m_block_end_out) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word %0d: median exp %h got %h, block_end exp %b got %b",
                                 results_seen, want.median, m_median,
                                 want.blk_end, m_block_end_out);
                end
            end
            results_seen++;
        end
    end

    initial begin
        mismatches   = 0;
        results_seen = 0;
    end

    // watchdog on cycles with no handshake at all
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/swmf_pkg.sv
hdl/swmf_cell.sv
hdl/swmf_median.sv
hdl/sliding_window_median_filter.sv
tb/sv/sliding_window_median_filter_tb.sv
